FILE: hw/rtl/hashed_lcg_range_rng_assert.svh
`ifndef HASHED_LCG_RANGE_RNG_ASSERT_SVH
`define HASHED_LCG_RANGE_RNG_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define HLR_ASSERT_IMPL(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("hlr assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define HLR_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("hlr assertion failed");

`endif

FILE: hw/rtl/hlr_pkg.sv
`default_nettype none
package hlr_pkg;

   localparam logic [31:0] LCG_MUL = 32'd1013904223;
   localparam logic [31:0] LCG_ADD = 32'd1664525;
   localparam logic [31:0] LCG_RESET = 32'd132;
   localparam logic [31:0] HASH_XOR = 32'd61;
   localparam logic [31:0] HASH_MUL = 32'h27d4eb2d;

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int SPAN_W = 17;
   localparam int DIVIDEND_W = 31;
   localparam int DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

   localparam logic [1:0] OP_SEED = 2'd0;
   localparam logic [1:0] OP_CHOICE = 2'd1;
   localparam logic [1:0] OP_RANGE = 2'd2;
   localparam logic [1:0] OP_DIR = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [31:0] seed;
      logic [SPAN_W-1:0] span;
      logic negate;
      logic signed [15:0] base;
   } entry_type;

   // XOR-folds a word down to its two low bits.
   function automatic logic [1:0] dir_fold(input logic [31:0] v);
      logic [31:0] f;
      f = v ^ (v >> 16);
      f = f ^ (f >> 8);
      f = f ^ (f >> 4);
      f = f ^ (f >> 2);
      return f[1:0];
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/hlr_front.sv
`default_nettype none
module hlr_front (
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_operation,
   input  wire logic [31:0]        req_seed_value,
   input  wire logic signed [15:0] req_choice_count,
   input  wire logic signed [15:0] req_range_first,
   input  wire logic signed [15:0] req_range_second,
   input  wire logic               q_full,
   output logic                    q_push,
   output hlr_pkg::entry_type      q_entry
);
   import hlr_pkg::*;

   logic signed [15:0] lo;
   logic signed [15:0] hi;
   logic [SPAN_W-1:0] count_ext;
   logic [SPAN_W-1:0] diff;

   assign req_stall = q_full;
   assign q_push = req_valid && !q_full;

   always_comb begin
      lo = (req_range_first < req_range_second) ? req_range_first : req_range_second;
      hi = (req_range_first < req_range_second) ? req_range_second : req_range_first;
      diff = {hi[15], hi} - {lo[15], lo};
      count_ext = {req_choice_count[15], req_choice_count};

      q_entry.op = req_operation;
      q_entry.seed = req_seed_value;
      q_entry.span = '0;
      q_entry.negate = 1'b0;
      q_entry.base = '0;
      case (req_operation)
         OP_CHOICE: begin
            q_entry.negate = req_choice_count[15];
            q_entry.span = req_choice_count[15] ? (~count_ext + 1'b1) : count_ext;
         end
         OP_RANGE: begin
            q_entry.span = diff + 1'b1;
            q_entry.base = lo;
         end
         default: begin
         end
      endcase
   end
endmodule
`default_nettype wire

FILE: hw/rtl/hlr_fifo.sv
`default_nettype none
module hlr_fifo #(
   parameter int DEPTH = hlr_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire hlr_pkg::entry_type push_entry,
   output logic                    full,
   output logic                    pop_valid,
   output hlr_pkg::entry_type      pop_entry,
   input  wire logic               pop
);
   import hlr_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop && pop_valid) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !(pop && pop_valid)) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop && pop_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/hlr_back.sv
`default_nettype none
module hlr_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire hlr_pkg::entry_type q_entry,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_picked_value,
   output logic signed [1:0]       rsp_step_x,
   output logic signed [1:0]       rsp_step_y
);
   import hlr_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_STEP = 3'd1;
   localparam logic [2:0] S_MIX = 3'd2;
   localparam logic [2:0] S_HMUL = 3'd3;
   localparam logic [2:0] S_FOLD = 3'd4;
   localparam logic [2:0] S_DIV = 3'd5;
   localparam logic [2:0] S_OUT = 3'd6;

   logic [2:0] st_ff, st_in;
   logic [31:0] gen_ff, gen_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] op_ff, op_in;
   logic [SPAN_W-1:0] span_ff, span_in;
   logic neg_ff, neg_in;
   logic signed [15:0] base_ff, base_in;
   logic [31:0] work_ff, work_in;
   logic [SPAN_W-1:0] rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0] dir_ff, dir_in;
   logic signed [15:0] picked_ff, picked_in;
   logic signed [1:0] sx_ff, sx_in;
   logic signed [1:0] sy_ff, sy_in;

   logic out_free;
   logic [31:0] mix_b;
   logic [31:0] tail;
   logic [SPAN_W:0] trial;
   logic [15:0] mag;
   logic signed [1:0] sgn;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop = (st_ff == S_IDLE) && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_picked_value = picked_ff;
   assign rsp_step_x = sx_ff;
   assign rsp_step_y = sy_ff;

   always_comb begin
      st_in = st_ff;
      gen_in = gen_ff;
      op_in = op_ff;
      span_in = span_ff;
      neg_in = neg_ff;
      base_in = base_ff;
      work_in = work_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      dir_in = dir_ff;
      picked_in = picked_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      mix_b = work_ff + (work_ff << 3);
      tail = work_ff ^ (work_ff >> 15);
      trial = {rem_ff, work_ff[DIVIDEND_W-1]};
      mag = rem_ff[15:0];
      sgn = dir_ff[1] ? 2'sb11 : 2'sb01;

      case (st_ff)
         S_IDLE: begin
            if (q_valid) begin
               op_in = q_entry.op;
               span_in = q_entry.span;
               neg_in = q_entry.negate;
               base_in = q_entry.base;
               rem_in = '0;
               dir_in = '0;
               work_in = 32'(gen_ff * LCG_MUL);
               case (q_entry.op)
                  OP_SEED: begin
                     gen_in = q_entry.seed;
                     st_in = S_OUT;
                  end
                  OP_DIR: begin
                     st_in = S_STEP;
                  end
                  default: begin
                     st_in = (q_entry.span[SPAN_W-1:1] == '0) ? S_OUT : S_STEP;
                  end
               endcase
            end
         end
         S_STEP: begin
            gen_in = work_ff + LCG_ADD;
            if (op_ff == OP_DIR) begin
               dir_in = dir_fold(gen_in);
               st_in = S_OUT;
            end else begin
               work_in = gen_in ^ HASH_XOR ^ (gen_in >> 16);
               st_in = S_MIX;
            end
         end
         S_MIX: begin
            work_in = mix_b ^ (mix_b >> 4);
            st_in = S_HMUL;
         end
         S_HMUL: begin
            work_in = 32'(work_ff * HASH_MUL);
            st_in = S_FOLD;
         end
         S_FOLD: begin
            work_in = tail >> 1;
            rem_in = '0;
            cnt_in = DIV_LAST;
            st_in = S_DIV;
         end
         S_DIV: begin
            if (trial >= {1'b0, span_ff}) begin
               rem_in = SPAN_W'(trial - {1'b0, span_ff});
            end else begin
               rem_in = trial[SPAN_W-1:0];
            end
            work_in = work_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               st_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               picked_in = '0;
               sx_in = '0;
               sy_in = '0;
               case (op_ff)
                  OP_CHOICE, OP_RANGE: begin
                     picked_in = neg_ff ? -$signed(mag) : base_ff + $signed(mag);
                  end
                  OP_DIR: begin
                     if (dir_ff[0]) begin
                        sy_in = sgn;
                     end else begin
                        sx_in = sgn;
                     end
                  end
                  default: begin
                  end
               endcase
               st_in = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         gen_ff <= LCG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         gen_ff <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      span_ff <= span_in;
      neg_ff <= neg_in;
      base_ff <= base_in;
      work_ff <= work_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      dir_ff <= dir_in;
      picked_ff <= picked_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
   end
endmodule
`default_nettype wire

FILE: hw/rtl/hashed_lcg_range_rng.sv
// Random request unit with a 32-bit LCG state and a hashed, range-reduced output.
// Request channel (req_): one word per request carries an operation (seed, choice,
// range or direction) and its operands; it is taken when req_valid is high and
// req_stall is low. A small queue holds accepted words, so req_stall rises only
// when the queue is full.
// Response channel (rsp_): exactly one word per request, in request order, held
// in an output register while rsp_stall is high; the sequencer waits with its
// next word until that register is free, and the queue fills behind it.
// The sequencer takes a seed word, or a choice or range of fewer than two values,
// straight to its output state; a direction word first takes an LCG step. Other
// choices and ranges take the LCG step and the hash stages (mix, multiply, fold),
// then a radix-2 remainder loop of 31 steps, one dividend bit per cycle, and then
// the output state. A new word starts only after the previous one has left the
// sequencer.
// Reset is synchronous: the state returns to 132, the queue empties and no
// response is pending.
`default_nettype none
`include "hashed_lcg_range_rng_assert.svh"
module hashed_lcg_range_rng #(
   parameter int QUEUE_DEPTH = hlr_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_operation,
   input  wire logic [31:0]        req_seed_value,
   input  wire logic signed [15:0] req_choice_count,
   input  wire logic signed [15:0] req_range_first,
   input  wire logic signed [15:0] req_range_second,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_picked_value,
   output logic signed [1:0]       rsp_step_x,
   output logic signed [1:0]       rsp_step_y
);
   import hlr_pkg::*;

   logic q_full;
   logic q_push;
   entry_type push_entry;
   logic q_valid;
   entry_type pop_entry;
   logic q_pop;

   hlr_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_seed_value   (req_seed_value),
      .req_choice_count (req_choice_count),
      .req_range_first  (req_range_first),
      .req_range_second (req_range_second),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (push_entry)
   );

   hlr_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop_entry  (pop_entry),
      .pop        (q_pop)
   );

   hlr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_entry          (pop_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_picked_value (rsp_picked_value),
      .rsp_step_x       (rsp_step_x),
      .rsp_step_y       (rsp_step_y)
   );

   `HLR_ASSERT_NEXT(a_push_fills, q_push && !q_valid, q_valid)
   `HLR_ASSERT_IMPL(a_one_axis, rsp_valid, rsp_step_x == 2'sb00 || rsp_step_y == 2'sb00)
   `HLR_ASSERT_IMPL(a_unit_step, rsp_valid, rsp_step_x != 2'sb10 && rsp_step_y != 2'sb10)
   `HLR_ASSERT_IMPL(a_dir_no_pick, rsp_valid && {rsp_step_x, rsp_step_y} != '0, rsp_picked_value == '0)
endmodule
`default_nettype wire

FILE: tb/tb_hashed_lcg_range_rng.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_hashed_lcg_range_rng;
   import hlr_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_WORDS = 1025;
   localparam int SETTLE_CYCLES = 60;

   typedef struct packed {
      logic signed [15:0] value;
      logic signed [1:0] sx;
      logic signed [1:0] sy;
   } draw_result_type;

   class pick_scoreboard_type;
      bit [31:0] lcg_state;
      draw_result_type pending_draws[$];
      int unsigned mismatches;
      int unsigned checked;

      function new();
         lcg_state = LCG_RESET;
         mismatches = 0;
         checked = 0;
      endfunction

      function bit [31:0] step_lcg();
         lcg_state = lcg_state * LCG_MUL + LCG_ADD;
         return lcg_state;
      endfunction

      function bit [31:0] draw_below(bit [31:0] span);
         bit [31:0] v;
         if (span < 2) begin
            return 0;
         end
         v = step_lcg();
         v = (v ^ HASH_XOR) ^ (v >> 16);
         v = v + (v << 3);
         v = v ^ (v >> 4);
         v = v * HASH_MUL;
         v = v ^ (v >> 15);
         v = v >> 1;
         return v % span;
      endfunction

      function void note_request(logic [1:0] op, logic [31:0] seed,
                                 logic signed [15:0] count,
                                 logic signed [15:0] first,
                                 logic signed [15:0] second);
         draw_result_type r;
         int n;
         int a;
         int b;
         int lo;
         int hi;
         int picked;
         int sign;
         bit [31:0] v;
         r.value = '0;
         r.sx = '0;
         r.sy = '0;
         case (op)
            OP_SEED: begin
               lcg_state = seed;
            end
            OP_CHOICE: begin
               n = count;
               if (n < 0) begin
                  picked = int'(draw_below(-n));
                  picked = -picked;
               end else begin
                  picked = int'(draw_below(n));
               end
               r.value = picked[15:0];
            end
            OP_RANGE: begin
               a = first;
               b = second;
               lo = (a < b) ? a : b;
               hi = (a < b) ? b : a;
               picked = lo + int'(draw_below(hi - lo + 1));
               r.value = picked[15:0];
            end
            OP_DIR: begin
               v = step_lcg();
               v = v ^ (v >> 16);
               v = v ^ (v >> 8);
               v = v ^ (v >> 4);
               v = v ^ (v >> 2);
               sign = v[1] ? -1 : 1;
               if (v[0]) begin
                  r.sy = sign[1:0];
               end else begin
                  r.sx = sign[1:0];
               end
            end
            default: begin
            end
         endcase
         pending_draws.push_back(r);
      endfunction

      task report_mismatch(string line);
         $display("MISMATCH at %0t: %s", $realtime, line);
         mismatches++;
      endtask

      task check_response(logic signed [15:0] picked, logic signed [1:0] sx,
                          logic signed [1:0] sy);
         draw_result_type want;
         if (pending_draws.size() == 0) begin
            report_mismatch($sformatf("word with no request pending: value %0d step %0d,%0d",
                                      picked, sx, sy));
            return;
         end
         want = pending_draws.pop_front();
         if (picked !== want.value) begin
            report_mismatch($sformatf("word %0d picked_value got %0d expected %0d",
                                      checked, picked, want.value));
         end
         if (sx !== want.sx) begin
            report_mismatch($sformatf("word %0d step_x got %0d expected %0d",
                                      checked, sx, want.sx));
         end
         if (sy !== want.sy) begin
            report_mismatch($sformatf("word %0d step_y got %0d expected %0d",
                                      checked, sy, want.sy));
         end
         checked++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_operation = OP_SEED;
   logic [31:0] req_seed_value = '0;
   logic signed [15:0] req_choice_count = '0;
   logic signed [15:0] req_range_first = '0;
   logic signed [15:0] req_range_second = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_picked_value;
   logic signed [1:0] rsp_step_x;
   logic signed [1:0] rsp_step_y;

   bit quiet = 1'b0;
   int idle_cycles = 0;
   int op_total[4];
   int small_counts = 0;
   int equal_ends = 0;
   pick_scoreboard_type sb = new();

   hashed_lcg_range_rng dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_seed_value(req_seed_value),
      .req_choice_count(req_choice_count),
      .req_range_first(req_range_first),
      .req_range_second(req_range_second),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_picked_value(rsp_picked_value),
      .rsp_step_x(rsp_step_x),
      .rsp_step_y(rsp_step_y)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 12);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         sb.check_response(rsp_picked_value, rsp_step_x, rsp_step_y);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d words outstanding.",
                     sb.pending_draws.size());
            $display("FAIL hashed_lcg_range_rng");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [1:0] op, input logic [31:0] seed,
                               input logic signed [15:0] count,
                               input logic signed [15:0] first,
                               input logic signed [15:0] second);
      if (!quiet) begin
         while ($urandom_range(99) < 12) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_seed_value <= seed;
      req_choice_count <= count;
      req_range_first <= first;
      req_range_second <= second;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, seed, count, first, second);
      op_total[op]++;
      if (op == OP_CHOICE && count >= -1 && count <= 1) begin
         small_counts++;
      end
      if (op == OP_RANGE && first == second) begin
         equal_ends++;
      end
   endtask

   initial begin
      int i;
      int pick;
      logic [1:0] op;
      logic [31:0] seed;
      logic signed [15:0] count;
      logic signed [15:0] first;
      logic signed [15:0] second;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(OP_DIR, 32'h0, 16'sd0, 16'sd0, 16'sd0);
      send_request(OP_CHOICE, 32'h0, 16'sd10, 16'sd0, 16'sd0);
      send_request(OP_CHOICE, 32'h0, 16'sd0, 16'sd0, 16'sd0);
      send_request(OP_CHOICE, 32'h0, 16'sd1, 16'sd0, 16'sd0);
      send_request(OP_CHOICE, 32'h0, -16'sd1, 16'sd0, 16'sd0);
      send_request(OP_CHOICE, 32'h0, 16'sd2, 16'sd0, 16'sd0);
      send_request(OP_CHOICE, 32'h0, -16'sd2, 16'sd0, 16'sd0);
      send_request(OP_CHOICE, 32'h0, 16'sd32767, 16'sd0, 16'sd0);
      send_request(OP_CHOICE, 32'h0, -16'sd32767, 16'sd0, 16'sd0);
      send_request(OP_CHOICE, 32'h0, 16'h8000, 16'sd0, 16'sd0);
      send_request(OP_RANGE, 32'h0, 16'sd0, 16'sd77, 16'sd77);
      send_request(OP_RANGE, 32'h0, 16'sd0, 16'h8000, 16'h8000);
      send_request(OP_RANGE, 32'h0, 16'sd0, 16'h8000, 16'sd32767);
      send_request(OP_RANGE, 32'h0, 16'sd0, 16'sd32767, 16'h8000);
      send_request(OP_RANGE, 32'h0, 16'sd0, 16'sd5, -16'sd3);
      send_request(OP_SEED, 32'h0, 16'sd0, 16'sd0, 16'sd0);
      send_request(OP_DIR, 32'h0, 16'sd0, 16'sd0, 16'sd0);
      send_request(OP_CHOICE, 32'h0, 16'sd100, 16'sd0, 16'sd0);
      send_request(OP_SEED, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 16'sd0);
      send_request(OP_RANGE, 32'h0, 16'sd0, 16'sd0, 16'sd1);
      send_request(OP_DIR, 32'h0, 16'sd0, 16'sd0, 16'sd0);
      send_request(OP_DIR, 32'h0, 16'sd0, 16'sd0, 16'sd0);
      send_request(OP_DIR, 32'h0, 16'sd0, 16'sd0, 16'sd0);
      send_request(OP_SEED, 32'hA5A5_5A5A, 16'sd0, 16'sd0, 16'sd0);
      send_request(OP_RANGE, 32'h0, 16'sd0, 16'sd32767, 16'sd32767);

      for (i = 0; i < RANDOM_WORDS; i++) begin
         quiet = (i >= 400 && i < 650);
         op = 2'($urandom_range(3));
         seed = $urandom;
         count = 16'($urandom);
         first = 16'($urandom);
         second = 16'($urandom);
         pick = $urandom_range(7);
         if (op == OP_CHOICE && pick < 2) begin
            count = 16'($signed($urandom_range(4)) - 2);
         end else if (op == OP_RANGE && pick == 0) begin
            second = first;
         end else if (op == OP_RANGE && pick < 3) begin
            second = first + 16'($signed($urandom_range(8)) - 4);
         end
         send_request(op, seed, count, first, second);
      end
      req_valid <= 1'b0;
      quiet = 1'b0;

      while (sb.pending_draws.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d seed, %0d choice, %0d range and %0d direction words;",
               op_total[OP_SEED], op_total[OP_CHOICE], op_total[OP_RANGE],
               op_total[OP_DIR]);
      $display("checked %0d responses, %0d small counts, %0d equal ranges, %0d mismatches.",
               sb.checked, small_counts, equal_ends, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("PASS hashed_lcg_range_rng");
      end else begin
         $display("FAIL hashed_lcg_range_rng");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/hlr_pkg.sv
hw/rtl/hlr_front.sv
hw/rtl/hlr_fifo.sv
hw/rtl/hlr_back.sv
hw/rtl/hashed_lcg_range_rng.sv
tb/tb_hashed_lcg_range_rng.sv
